FILE: hdl/mpe_pkg.sv
// Shared constants and types for the matrix product engine.
package mpe_pkg;
    localparam int MAX_DIM_DEF   = 8;
    localparam int ELEM_BITS_DEF = 16;
    localparam int CFG_W   = 4;
    localparam int IDX_W   = 3;
    localparam int VAL_W   = 16;
    localparam int OUT_W   = 40;

    localparam logic [1:0] CMD_WR_A  = 2'd0;
    localparam logic [1:0] CMD_WR_B  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [1:0] REG_A_ROWS = 2'd0;
    localparam logic [1:0] REG_A_COLS = 2'd1;
    localparam logic [1:0] REG_B_ROWS = 2'd2;
    localparam logic [1:0] REG_B_COLS = 2'd3;

    localparam logic [1:0] KIND_WR_A  = 2'd0;
    localparam logic [1:0] KIND_WR_B  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    // One classified request as it waits in the queue.
    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_req;
endpackage

FILE: hdl/mpe_front.sv
// Front end: accepts requests, drops unused or out-of-range ones, queues the rest.
module mpe_front #(
    parameter int MAX_DIM = mpe_pkg::MAX_DIM_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_cmd,
    input  logic [mpe_pkg::IDX_W-1:0] i_row,
    input  logic [mpe_pkg::IDX_W-1:0] i_col,
    input  logic [mpe_pkg::VAL_W-1:0] i_value,
    output logic                     o_q_valid,
    output mpe_pkg::t_req            o_q_req,
    input  logic                     i_q_pop
);
    localparam int DEPTH = 4;
    mpe_pkg::t_req r_mem [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic push, keep, inr;

    assign inr  = (32'(i_row) < MAX_DIM) && (32'(i_col) < MAX_DIM);
    assign keep = (i_cmd == mpe_pkg::CMD_START) ||
                  (((i_cmd == mpe_pkg::CMD_WR_A) || (i_cmd == mpe_pkg::CMD_WR_B)) && inr);
    assign o_stall   = (r_cnt == 3'(DEPTH));
    assign push      = i_valid && !o_stall && keep;
    assign o_q_valid = (r_cnt != 3'd0);
    assign o_q_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{kind: i_cmd, row: i_row, col: i_col, value: i_value};
        end
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (i_q_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(i_q_pop);
        end
    end
endmodule

FILE: hdl/mpe_back.sv
// Back end: element stores, shape decode and the multiply-accumulate sequencer.
module mpe_back #(
    parameter int MAX_DIM   = mpe_pkg::MAX_DIM_DEF,
    parameter int ELEM_BITS = mpe_pkg::ELEM_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [mpe_pkg::CFG_W-1:0] i_a_rows,
    input  logic [mpe_pkg::CFG_W-1:0] i_a_cols,
    input  logic [mpe_pkg::CFG_W-1:0] i_b_rows,
    input  logic [mpe_pkg::CFG_W-1:0] i_b_cols,
    input  logic                      i_q_valid,
    input  mpe_pkg::t_req             i_q_req,
    output logic                      o_q_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [mpe_pkg::IDX_W-1:0] o_out_row,
    output logic [mpe_pkg::IDX_W-1:0] o_out_col,
    output logic signed [mpe_pkg::OUT_W-1:0] o_out_value,
    output logic                      o_last,
    output logic                      o_error
);
    localparam int IW = $clog2(MAX_DIM);
    localparam int AW = 2 * IW;
    localparam int NENT = 1 << AW;
    localparam int PW = 2 * ELEM_BITS;
    localparam int SW = PW + 4;
    localparam int DW = mpe_pkg::CFG_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [ELEM_BITS-1:0] r_amem [NENT];
    logic [ELEM_BITS-1:0] r_bmem [NENT];
    logic [ELEM_BITS-1:0] r_ad, r_bd;
    logic signed [PW-1:0] r_prod;
    logic signed [SW-1:0] r_acc;
    logic [2:0] r_st;
    logic [IW-1:0] r_i, r_j, r_k;
    logic r_had;
    logic [IW-1:0] ar, ac, br, bc, ncol, nk;
    logic ld, wr_a, wr_b;
    logic [AW-1:0] waddr, aaddr, baddr;
    logic kdone, jdone, idone;
    logic signed [mpe_pkg::OUT_W-1:0] res;

    function automatic logic [IW-1:0] eff(input logic [DW-1:0] d);
        logic [IW-1:0] v;
        if (d == '0) v = '0;
        else if (32'(d) > MAX_DIM) v = IW'(MAX_DIM - 1);
        else v = IW'(d - DW'(1));
        return v;
    endfunction

    assign ar = eff(i_a_rows);
    assign ac = eff(i_a_cols);
    assign br = eff(i_b_rows);
    assign bc = eff(i_b_cols);
    assign ncol = r_had ? ac : bc;
    assign nk   = r_had ? '0 : br;

    // Writes retire straight from the queue; a start waits for an empty output.
    assign ld    = (r_st == ST_IDLE) && i_q_valid;
    assign wr_a  = ld && (i_q_req.kind == mpe_pkg::KIND_WR_A);
    assign wr_b  = ld && (i_q_req.kind == mpe_pkg::KIND_WR_B);
    assign o_q_pop = ld && (i_q_req.kind != mpe_pkg::KIND_START || !o_valid);
    assign waddr = {i_q_req.row[IW-1:0], i_q_req.col[IW-1:0]};
    assign aaddr = {r_i, r_had ? r_j : r_k};
    assign baddr = {r_had ? r_i : r_k, r_j};
    assign kdone = (r_k == nk);
    assign jdone = (r_j == ncol);
    assign idone = (r_i == ar);
    assign res   = mpe_pkg::OUT_W'(r_acc);

    always_ff @(posedge i_clk) begin
        if (wr_a) r_amem[waddr] <= ELEM_BITS'($signed(i_q_req.value));
        if (wr_b) r_bmem[waddr] <= ELEM_BITS'($signed(i_q_req.value));
        r_ad   <= r_amem[aaddr];
        r_bd   <= r_bmem[baddr];
        r_prod <= $signed(r_ad) * $signed(r_bd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall) o_valid <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (o_q_pop && i_q_req.kind == mpe_pkg::KIND_START) begin
                        r_i <= '0; r_j <= '0; r_k <= '0; r_acc <= '0;
                        r_had <= (ar == br) && (ac == bc);
                        if (!((ar == br) && (ac == bc)) && (ac != br)) begin
                            o_valid <= 1'b1;
                            o_out_row <= '0; o_out_col <= '0; o_out_value <= '0;
                            o_last <= 1'b1; o_error <= 1'b1;
                        end else begin
                            r_st <= ST_READ;
                        end
                    end
                end
                ST_READ: r_st <= ST_MUL;
                ST_MUL:  r_st <= ST_ACC;
                ST_ACC: begin
                    r_acc <= r_acc + SW'(r_prod);
                    if (kdone) r_st <= ST_OUT;
                    else begin
                        r_k <= r_k + IW'(1);
                        r_st <= ST_READ;
                    end
                end
                ST_OUT: begin
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                        o_out_row <= mpe_pkg::IDX_W'(r_i);
                        o_out_col <= mpe_pkg::IDX_W'(r_j);
                        o_out_value <= res;
                        o_last <= idone && jdone;
                        o_error <= 1'b0;
                        r_acc <= '0; r_k <= '0;
                        if (jdone) begin
                            r_j <= '0;
                            r_i <= r_i + IW'(1);
                        end else begin
                            r_j <= r_j + IW'(1);
                        end
                        r_st <= (idone && jdone) ? ST_IDLE : ST_READ;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

FILE: hdl/matrix_product_engine_core.sv
// Top level of the matrix product engine: configuration registers, front and back ends.
// Element writes retire at one per cycle while the back end is idle, through a four-entry request queue.
// A start emits results row-major; each result runs the single shared multiply-accumulate
// loop of read, multiply and accumulate once per inner element (once for a Hadamard product),
// then an output step. A shape error gives one result with the error bit set.
module matrix_product_engine_core #(
    parameter int MAX_DIM   = mpe_pkg::MAX_DIM_DEF,
    parameter int ELEM_BITS = mpe_pkg::ELEM_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [mpe_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_cmd,
    input  logic [mpe_pkg::IDX_W-1:0] i_row,
    input  logic [mpe_pkg::IDX_W-1:0] i_col,
    input  logic signed [mpe_pkg::VAL_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [mpe_pkg::IDX_W-1:0] o_out_row,
    output logic [mpe_pkg::IDX_W-1:0] o_out_col,
    output logic signed [mpe_pkg::OUT_W-1:0] o_out_value,
    output logic                      o_last,
    output logic                      o_error
);
    logic [mpe_pkg::CFG_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic q_valid, q_pop;
    mpe_pkg::t_req q_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= 4'd8; r_a_cols <= 4'd8; r_b_rows <= 4'd8; r_b_cols <= 4'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mpe_pkg::REG_A_ROWS: r_a_rows <= i_cfg_data;
                mpe_pkg::REG_A_COLS: r_a_cols <= i_cfg_data;
                mpe_pkg::REG_B_ROWS: r_b_rows <= i_cfg_data;
                mpe_pkg::REG_B_COLS: r_b_cols <= i_cfg_data;
            endcase
        end
    end

    mpe_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_cmd, .i_row, .i_col,
        .i_value(i_value), .o_q_valid(q_valid), .o_q_req(q_req), .i_q_pop(q_pop)
    );

    mpe_back #(.MAX_DIM(MAX_DIM), .ELEM_BITS(ELEM_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_a_rows(r_a_rows), .i_a_cols(r_a_cols), .i_b_rows(r_b_rows), .i_b_cols(r_b_cols),
        .i_q_valid(q_valid), .i_q_req(q_req), .o_q_pop(q_pop),
        .o_valid, .i_stall, .o_out_row, .o_out_col, .o_out_value, .o_last, .o_error
    );
endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the matrix product engine core.
`timescale 1ns / 1ps

module tb_top;
    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int LONG_HOLD = 400;
    localparam int ITEM_TARGET = 470;

    typedef struct {
        logic [1:0]                       cmd;
        logic [mpe_pkg::IDX_W-1:0]        row;
        logic [mpe_pkg::IDX_W-1:0]        col;
        logic signed [mpe_pkg::VAL_W-1:0] value;
    } t_mat_req;

    typedef struct {
        logic [mpe_pkg::IDX_W-1:0]        row;
        logic [mpe_pkg::IDX_W-1:0]        col;
        logic signed [mpe_pkg::OUT_W-1:0] value;
        logic                             last;
        logic                             error;
    } t_mat_res;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [1:0]                       i_cfg_index = mpe_pkg::REG_A_ROWS;
    logic [mpe_pkg::CFG_W-1:0]        i_cfg_data = '0;
    logic                             i_valid = 1'b0;
    logic                             o_stall;
    logic [1:0]                       i_cmd = CMD_NOP;
    logic [mpe_pkg::IDX_W-1:0]        i_row = '0;
    logic [mpe_pkg::IDX_W-1:0]        i_col = '0;
    logic signed [mpe_pkg::VAL_W-1:0] i_value = '0;
    logic                             o_valid;
    logic                             i_stall = 1'b0;
    logic [mpe_pkg::IDX_W-1:0]        o_out_row;
    logic [mpe_pkg::IDX_W-1:0]        o_out_col;
    logic signed [mpe_pkg::OUT_W-1:0] o_out_value;
    logic                             o_last;
    logic                             o_error;

    matrix_product_engine_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_mat_req req_q[$];
    t_mat_res product_q[$];

    logic signed [mpe_pkg::VAL_W-1:0] a_mem[64];
    logic signed [mpe_pkg::VAL_W-1:0] b_mem[64];
    bit a_loaded[64];
    bit b_loaded[64];
    logic [mpe_pkg::CFG_W-1:0] dim_reg[4];

    int n_pushed = 0;
    int n_starts = 0;
    int n_shape_err = 0;
    int n_results = 0;
    int n_fail = 0;
    int cycles = 0;
    bit calm = 1'b0;
    bit hold_arm = 1'b0;

    function automatic int eff_dim(logic [mpe_pkg::CFG_W-1:0] d);
        if (d == 0) return 1;
        if (d > 8) return 8;
        return int'(d);
    endfunction

    // Expands one accepted request into the results it should produce.
    function automatic void predict_product(t_mat_req r);
        int ar, ac, br, bc;
        logic signed [mpe_pkg::OUT_W-1:0] acc;
        t_mat_res e;
        ar = eff_dim(dim_reg[mpe_pkg::REG_A_ROWS]);
        ac = eff_dim(dim_reg[mpe_pkg::REG_A_COLS]);
        br = eff_dim(dim_reg[mpe_pkg::REG_B_ROWS]);
        bc = eff_dim(dim_reg[mpe_pkg::REG_B_COLS]);
        if (r.cmd == mpe_pkg::CMD_WR_A) begin
            a_mem[r.row * 8 + r.col] = r.value;
        end else if (r.cmd == mpe_pkg::CMD_WR_B) begin
            b_mem[r.row * 8 + r.col] = r.value;
        end else if (r.cmd == mpe_pkg::CMD_START) begin
            n_starts++;
            if (ar == br && ac == bc) begin
                for (int i = 0; i < ar; i++)
                    for (int j = 0; j < ac; j++) begin
                        acc = a_mem[i * 8 + j] * b_mem[i * 8 + j];
                        e = '{mpe_pkg::IDX_W'(i), mpe_pkg::IDX_W'(j), acc,
                              (i == ar - 1 && j == ac - 1), 1'b0};
                        product_q.push_back(e);
                    end
            end else if (ac != br) begin
                n_shape_err++;
                product_q.push_back('{'0, '0, '0, 1'b1, 1'b1});
            end else begin
                for (int i = 0; i < ar; i++)
                    for (int j = 0; j < bc; j++) begin
                        acc = 0;
                        for (int k = 0; k < br; k++)
                            acc += a_mem[i * 8 + k] * b_mem[k * 8 + j];
                        e = '{mpe_pkg::IDX_W'(i), mpe_pkg::IDX_W'(j), acc,
                              (i == ar - 1 && j == bc - 1), 1'b0};
                        product_q.push_back(e);
                    end
            end
        end
    endfunction

    // Request driver with random gaps.
    always @(posedge i_clk) begin
        static int gap = 0;
        t_mat_req r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (gap > 0) begin
                gap--;
                i_valid <= 1'b0;
            end else if (req_q.size() > 0) begin
                r = req_q.pop_front();
                i_cmd <= r.cmd;
                i_row <= r.row;
                i_col <= r.col;
                i_value <= r.value;
                i_valid <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 18);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            predict_product('{i_cmd, i_row, i_col, i_value});
    end

    // Result receiver: random stall bursts plus one long hold-off.
    always @(posedge i_clk) begin
        static int burst = 0;
        static int hold = 0;
        static bit hold_done = 1'b0;
        if (hold_arm && !hold_done) begin
            hold = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold > 0) begin
            hold--;
            i_stall <= 1'b1;
        end else if (burst > 0) begin
            burst--;
            i_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 18) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_mat_res e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (product_q.size() == 0) begin
                $display("%0t: unexpected result row %0d col %0d value %0d",
                         $time, o_out_row, o_out_col, o_out_value);
                n_fail++;
            end else begin
                e = product_q.pop_front();
                if (o_out_row !== e.row || o_out_col !== e.col || o_out_value !== e.value
                    || o_last !== e.last || o_error !== e.error) begin
                    $display("%0t: mismatch expected row %0d col %0d value %0d last %0b err %0b",
                             $time, e.row, e.col, e.value, e.last, e.error);
                    $display("%0t:           actual row %0d col %0d value %0d last %0b err %0b",
                             $time, o_out_row, o_out_col, o_out_value, o_last, o_error);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL matrix_product_engine_core");
            $finish;
        end
    end

    function automatic logic signed [mpe_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return mpe_pkg::VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] pick_write();
        return ($urandom_range(0, 1) == 0) ? mpe_pkg::CMD_WR_A : mpe_pkg::CMD_WR_B;
    endfunction

    task automatic push_req(logic [1:0] cmd, int row, int col,
                            logic signed [mpe_pkg::VAL_W-1:0] v);
        req_q.push_back('{cmd, row[mpe_pkg::IDX_W-1:0], col[mpe_pkg::IDX_W-1:0], v});
        if (cmd == mpe_pkg::CMD_WR_A) a_loaded[row * 8 + col] = 1'b1;
        if (cmd == mpe_pkg::CMD_WR_B) b_loaded[row * 8 + col] = 1'b1;
        if (cmd != CMD_NOP) n_pushed++;
    endtask

    // Loads any element a start would read that has never been written, then queues the start.
    task automatic push_start();
        int ar, ac, br, bc;
        ar = eff_dim(dim_reg[mpe_pkg::REG_A_ROWS]);
        ac = eff_dim(dim_reg[mpe_pkg::REG_A_COLS]);
        br = eff_dim(dim_reg[mpe_pkg::REG_B_ROWS]);
        bc = eff_dim(dim_reg[mpe_pkg::REG_B_COLS]);
        for (int i = 0; i < ar; i++)
            for (int j = 0; j < ac; j++)
                if (!a_loaded[i * 8 + j]) push_req(mpe_pkg::CMD_WR_A, i, j, pick_value());
        for (int i = 0; i < br; i++)
            for (int j = 0; j < bc; j++)
                if (!b_loaded[i * 8 + j]) push_req(mpe_pkg::CMD_WR_B, i, j, pick_value());
        push_req(mpe_pkg::CMD_START, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
    endtask

    // Waits until the block is drained; writes leave no result, so allow extra cycles.
    task automatic wait_idle();
        do begin
            while (req_q.size() > 0 || i_valid || product_q.size() > 0) @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end while (req_q.size() > 0 || i_valid || product_q.size() > 0);
    endtask

    task automatic set_dims(int ar, int ac, int br, int bc);
        int v[4];
        v = '{ar, ac, br, bc};
        for (int i = 0; i < 4; i++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_index <= i[1:0];
            i_cfg_data <= v[i][mpe_pkg::CFG_W-1:0];
            dim_reg[i] = v[i][mpe_pkg::CFG_W-1:0];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pick_dim();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 15;
            2: return 8;
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    initial begin
        int ar, ac, br, bc;
        bit first;
        for (int i = 0; i < 4; i++) dim_reg[i] = 4'd8;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: 1x1 extremes, unused command, a small matrix product, shape error,
        // and out-of-range dimensions that clamp to 1 and 8.
        set_dims(1, 1, 1, 1);
        push_req(mpe_pkg::CMD_WR_A, 0, 0, 16'sh8000);
        push_req(mpe_pkg::CMD_WR_B, 0, 0, 16'sh8000);
        push_req(mpe_pkg::CMD_START, 0, 0, 16'sh0000);
        push_req(mpe_pkg::CMD_WR_B, 0, 0, 16'sh7fff);
        push_req(CMD_NOP, 7, 7, 16'sh1234);
        push_req(mpe_pkg::CMD_START, 7, 7, 16'shffff);
        wait_idle();
        set_dims(2, 3, 3, 2);
        push_start();
        wait_idle();
        set_dims(2, 3, 2, 2);
        push_start();
        wait_idle();
        set_dims(0, 15, 8, 0);
        push_start();

        first = 1'b1;
        while (n_pushed < ITEM_TARGET) begin
            wait_idle();
            if (first) begin
                {ar, ac, br, bc} = {32'd8, 32'd8, 32'd8, 32'd8};
            end else begin
                ar = pick_dim();
                ac = pick_dim();
                case ($urandom_range(0, 5))
                    0, 1: begin br = ar; bc = ac; end
                    2, 3: begin br = ac; bc = pick_dim(); end
                    default: begin br = pick_dim(); bc = pick_dim(); end
                endcase
            end
            set_dims(ar, ac, br, bc);
            repeat ($urandom_range(0, 12))
                push_req(pick_write(), $urandom_range(0, 7), $urandom_range(0, 7),
                         pick_value());
            if ($urandom_range(0, 4) == 0)
                push_req(CMD_NOP, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
            push_start();
            if ($urandom_range(0, 3) == 0) push_start();
            if (first) begin
                // Keep offering writes while the receiver holds off.
                repeat (20)
                    push_req(pick_write(), $urandom_range(0, 7), $urandom_range(0, 7),
                             pick_value());
                hold_arm = 1'b1;
                first = 1'b0;
            end
            if (n_pushed > ITEM_TARGET - 60) calm = 1'b1;
        end

        wait_idle();
        if (product_q.size() != 0) begin
            $display("%0d expected results never arrived", product_q.size());
            n_fail++;
        end
        $display("Covered %0d requests, %0d starts (%0d shape errors), %0d results checked.",
                 n_pushed, n_starts, n_shape_err, n_results);
        if (n_fail == 0) begin
            $display("PASS matrix_product_engine_core");
        end else begin
            $display("FAIL matrix_product_engine_core");
        end
        $finish;
    end
endmodule

FILE: files.f
hdl/mpe_pkg.sv
hdl/mpe_front.sv
hdl/mpe_back.sv
hdl/matrix_product_engine_core.sv
verif/tb_top.sv
